### hw/rtl/wlvc_pkg.sv
// wlvc_pkg: shared types and constants for the water leak valve controller
// holds valve command codes, register indexes, reset values and the config/result structs
// no dependencies
`default_nettype none

package wlvc_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int PULSE_W = 16;
    localparam int MS_W    = 22;
    localparam int CNT_W   = 8;
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;

    // valve command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_INTERVAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_TRIP     = 3'd1;
    localparam logic [IDX_W-1:0] REG_CLEAR    = 3'd2;
    localparam logic [IDX_W-1:0] REG_GUARD    = 3'd3;
    localparam logic [IDX_W-1:0] REG_SUSPEND  = 3'd4;

    // register reset values
    localparam logic [MS_W-1:0]  RST_INTERVAL = 22'd10000;
    localparam logic [CNT_W-1:0] RST_TRIP     = 8'd10;
    localparam logic [CNT_W-1:0] RST_CLEAR    = 8'd3;
    localparam logic [MS_W-1:0]  RST_GUARD    = 22'd12000;

    localparam logic [PULSE_W-1:0] PULSE_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    typedef struct packed {
        logic [MS_W-1:0]  interval_ms;
        logic [CNT_W-1:0] trip_count;
        logic [CNT_W-1:0] clear_count;
        logic [MS_W-1:0]  guard_ms;
        logic             suspend;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0] valve_command;
        logic             leak_active;
        logic [CNT_W-1:0] wet_windows;
        logic             valve_is_open;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/wlvc_core.sv
// wlvc_core: leak episode state and per-poll evaluation
// state updates on i_fire, the result of that poll is presented combinationally
// depends on wlvc_pkg
`default_nettype none

module wlvc_core
    import wlvc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire t_cfg               i_cfg,
    input  wire logic [TIME_W-1:0]  i_now,
    input  wire logic [PULSE_W-1:0] i_pulses,
    output t_result                 o_result
);

    logic [PULSE_W-1:0] r_pulse_total, n_pulse_total;
    logic               r_episode_on,  n_episode_on;
    logic [TIME_W-1:0]  r_window_start, n_window_start;
    logic [CNT_W-1:0]   r_wet_count,   n_wet_count;
    logic [CNT_W-1:0]   r_dry_count,   n_dry_count;
    logic               r_open_flag,   n_open_flag;
    logic               r_closed_once, n_closed_once;
    logic [TIME_W-1:0]  r_last_open,   n_last_open;
    logic [TIME_W-1:0]  r_last_close,  n_last_close;
    logic [CMD_W-1:0]   cmd;

    logic [PULSE_W:0]   pulse_sum;
    logic [PULSE_W-1:0] pulse_sat;
    logic               start;
    logic [TIME_W-1:0]  ws1;
    logic [PULSE_W-1:0] pt1;
    logic               ep1;
    logic               win_end;
    logic               wet_win;
    logic [CNT_W-1:0]   wet2;
    logic [CNT_W-1:0]   dry2;
    logic               open_ok;
    logic               close_ok;

    // saturating pulse accumulation
    assign pulse_sum = {1'b0, r_pulse_total} + {1'b0, i_pulses};
    assign pulse_sat = pulse_sum[PULSE_W] ? PULSE_MAX : pulse_sum[PULSE_W-1:0];

    // episode start and window end
    assign start   = !r_episode_on && (pulse_sat != '0);
    assign ws1     = start ? i_now : r_window_start;
    assign pt1     = start ? '0 : pulse_sat;
    assign ep1     = r_episode_on || start;
    assign win_end = ep1 && ((i_now - ws1) >= {{(TIME_W-MS_W){1'b0}}, i_cfg.interval_ms});

    // window classification with saturating counts
    assign wet_win = (pt1 != '0);
    assign wet2    = (wet_win && r_wet_count != CNT_MAX) ? r_wet_count + CNT_W'(1)
                   : r_wet_count;
    assign dry2    = wet_win ? '0
                   : ((r_dry_count != CNT_MAX) ? r_dry_count + CNT_W'(1) : r_dry_count);

    // valve actions, open takes priority
    assign open_ok  = (dry2 >= i_cfg.clear_count) && r_closed_once
                   && ((i_now - r_last_close) > {{(TIME_W-MS_W){1'b0}}, i_cfg.guard_ms});
    assign close_ok = !open_ok && (wet2 >= i_cfg.trip_count) && r_open_flag
                   && ((i_now - r_last_open) > {{(TIME_W-MS_W){1'b0}}, i_cfg.guard_ms});

    // next state
    always_comb begin
        n_pulse_total  = r_pulse_total;
        n_episode_on   = r_episode_on;
        n_window_start = r_window_start;
        n_wet_count    = r_wet_count;
        n_dry_count    = r_dry_count;
        n_open_flag    = r_open_flag;
        n_closed_once  = r_closed_once;
        n_last_open    = r_last_open;
        n_last_close   = r_last_close;
        cmd            = CMD_NONE;
        if (i_cfg.suspend) begin
            n_pulse_total = pulse_sat;
        end else if (win_end) begin
            n_pulse_total  = '0;
            n_episode_on   = ep1;
            n_window_start = i_now;
            n_wet_count    = wet2;
            n_dry_count    = dry2;
            if (open_ok) begin
                cmd            = CMD_OPEN;
                n_last_open    = i_now;
                n_open_flag    = 1'b1;
                n_episode_on   = 1'b0;
                n_wet_count    = '0;
                n_dry_count    = '0;
                n_window_start = '0;
            end else if (close_ok) begin
                cmd           = CMD_CLOSE;
                n_last_close  = i_now;
                n_closed_once = 1'b1;
                n_open_flag   = 1'b0;
            end
        end else begin
            n_pulse_total  = pt1;
            n_episode_on   = ep1;
            n_window_start = ws1;
        end
    end

    // result reflects state after the poll
    assign o_result.valve_command = cmd;
    assign o_result.leak_active   = n_episode_on;
    assign o_result.wet_windows   = n_wet_count;
    assign o_result.valve_is_open = n_open_flag;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_total  <= '0;
            r_episode_on   <= 1'b0;
            r_window_start <= '0;
            r_wet_count    <= '0;
            r_dry_count    <= '0;
            r_open_flag    <= 1'b1;
            r_closed_once  <= 1'b0;
            r_last_open    <= '0;
            r_last_close   <= '0;
        end else if (i_fire) begin
            r_pulse_total  <= n_pulse_total;
            r_episode_on   <= n_episode_on;
            r_window_start <= n_window_start;
            r_wet_count    <= n_wet_count;
            r_dry_count    <= n_dry_count;
            r_open_flag    <= n_open_flag;
            r_closed_once  <= n_closed_once;
            r_last_open    <= n_last_open;
            r_last_close   <= n_last_close;
        end
    end

    // an open ends the episode and clears the wet count
    a_open_ends_episode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && cmd == CMD_OPEN) |=> (!r_episode_on && r_wet_count == '0 && r_open_flag))
        else $error("open did not end the episode");

    // a reopen only ever follows an earlier close
    a_open_needs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && cmd == CMD_OPEN) |-> r_closed_once)
        else $error("open issued without a prior close");

    // a close leaves the valve marked closed
    a_close_marks_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && cmd == CMD_CLOSE) |=> (!r_open_flag && r_closed_once))
        else $error("close did not update valve state");

    // suspended polls touch only the pulse accumulator
    a_suspend_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cfg.suspend) |=> ($stable(r_episode_on) && $stable(r_wet_count)
            && $stable(r_dry_count) && $stable(r_open_flag) && $stable(r_window_start)))
        else $error("state changed while suspended");

endmodule

`default_nettype wire

### hw/rtl/water_leak_valve_controller_unit.sv
// water_leak_valve_controller_unit: top level with config registers, input and result registers
// instantiates wlvc_core; depends on wlvc_pkg
//
//  channel | direction | handshake                    | payload
//  in      | input     | i_in_valid / o_in_ready      | i_now_ms, i_new_pulses
//  out     | output    | o_out_valid / i_out_ready    | o_valve_command, o_leak_active,
//          |           |                              | o_wet_windows, o_valve_is_open
//  cfg     | input     | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// one poll per cycle sustained while results are taken; an accepted input beat passes through
// the input register, then evaluation against the state registers into the result register
// synchronous active-low reset sets config to defaults, resets the core state and clears the valid flags
// a held result stalls the evaluation stage; the input register still takes a beat when
// it is empty, and otherwise frees up in the same cycle the result is taken
`default_nettype none

module water_leak_valve_controller_unit
    import wlvc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_ready,
    input  wire logic [TIME_W-1:0]  i_now_ms,
    input  wire logic [PULSE_W-1:0] i_new_pulses,
    output      logic               o_out_valid,
    input  wire logic               i_out_ready,
    output      logic [CMD_W-1:0]   o_valve_command,
    output      logic               o_leak_active,
    output      logic [CNT_W-1:0]   o_wet_windows,
    output      logic               o_valve_is_open,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_index,
    input  wire logic [MS_W-1:0]    i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic [TIME_W-1:0]  r_in_now;
    logic [PULSE_W-1:0] r_in_pulses;
    logic               r_out_valid;
    t_result            r_out;
    t_result            eval_result;
    logic               eval_fire;
    logic               in_fire;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval_ms <= RST_INTERVAL;
            r_cfg.trip_count  <= RST_TRIP;
            r_cfg.clear_count <= RST_CLEAR;
            r_cfg.guard_ms    <= RST_GUARD;
            r_cfg.suspend     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_INTERVAL: r_cfg.interval_ms <= i_cfg_data;
                REG_TRIP:     r_cfg.trip_count  <= i_cfg_data[CNT_W-1:0];
                REG_CLEAR:    r_cfg.clear_count <= i_cfg_data[CNT_W-1:0];
                REG_GUARD:    r_cfg.guard_ms    <= i_cfg_data;
                REG_SUSPEND:  r_cfg.suspend     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign eval_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || eval_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_now    <= i_now_ms;
            r_in_pulses <= i_new_pulses;
        end
    end

    // evaluation
    wlvc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (eval_fire),
        .i_cfg    (r_cfg),
        .i_now    (r_in_now),
        .i_pulses (r_in_pulses),
        .o_result (eval_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eval_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_fire) begin
            r_out <= eval_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_valve_command = r_out.valve_command;
    assign o_leak_active   = r_out.leak_active;
    assign o_wet_windows   = r_out.wet_windows;
    assign o_valve_is_open = r_out.valve_is_open;

endmodule

`default_nettype wire
